FILE: design/bht_pkg.sv
`timescale 1ns / 1ps

package bht_pkg;

	localparam int BUTTON_COUNT_DEF = 8;
	localparam int INPUT_BITS       = 8;
	localparam int COUNT_W          = 8;
	localparam int QUERY_W          = 3;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 8;

	localparam logic [COUNT_W-1:0] RELEASED_MARK = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_TOP     = 8'd254;

	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_FRAMES   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 1'b1;

	localparam logic [CFG_DATA_W-1:0] HOLD_FRAMES_RST   = 8'd20;
	localparam logic [CFG_DATA_W-1:0] REPEAT_PERIOD_RST = 8'd0;

	typedef struct packed {
		logic [INPUT_BITS-1:0] buttons_down;
		logic                  frame_tick;
		logic [QUERY_W-1:0]    query_button;
	} in_item_t;

	typedef struct packed {
		logic [INPUT_BITS-1:0] pressed_mask;
		logic [INPUT_BITS-1:0] released_mask;
		logic [INPUT_BITS-1:0] held_mask;
		logic [INPUT_BITS-1:0] repeat_mask;
		logic [COUNT_W-1:0]    held_time;
	} out_item_t;

	// Broadcast to every lane
	typedef struct packed {
		logic         update;
		logic         tick;
		logic         rc_step;
		logic         rc_first;
		logic [2:0]   rc_bit;
	} lane_ctrl_t;

	typedef struct packed {
		logic pressed;
		logic released;
		logic held;
		logic rpt;
	} lane_flags_t;

endpackage

FILE: design/bht_lane.sv
`timescale 1ns / 1ps

module bht_lane import bht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic               down,
	input  logic [COUNT_W-1:0] hold_frames,
	input  logic [COUNT_W-1:0] repeat_period,
	output lane_flags_t        flags,
	output logic [COUNT_W-1:0] count_next
);

	logic [COUNT_W-1:0] count_q;
	// count_q mod repeat_period, kept in step with the counter
	logic [COUNT_W-1:0] rem_q;

	logic [COUNT_W-1:0] cnt_n;
	logic [COUNT_W-1:0] rem_n;
	logic               inc;
	logic [COUNT_W:0]   rem_inc;
	logic [COUNT_W-1:0] rc_base;
	logic [COUNT_W:0]   rc_t;
	logic [COUNT_W:0]   rc_r;
	logic               live;

	always_comb begin
		cnt_n = count_q;
		inc   = 1'b0;
		if (down) begin
			if (ctrl.tick) begin
				if (count_q == RELEASED_MARK) begin
					cnt_n = '0;
				end else if (count_q < COUNT_TOP) begin
					cnt_n = count_q + 8'd1;
					inc   = 1'b1;
				end
			end
		end else if (count_q != '0) begin
			cnt_n = (count_q == RELEASED_MARK) ? '0 : RELEASED_MARK;
		end
	end

	assign rem_inc = {1'b0, rem_q} + 9'd1;

	always_comb begin
		if (cnt_n == '0) begin
			rem_n = '0;
		end else if (inc) begin
			rem_n = (rem_inc == {1'b0, repeat_period}) ? '0 : rem_inc[COUNT_W-1:0];
		end else begin
			rem_n = rem_q;
		end
	end

	// One restoring step of count_q mod repeat_period, MSB first
	assign rc_base = ctrl.rc_first ? '0 : rem_q;
	assign rc_t    = {rc_base, count_q[ctrl.rc_bit]};
	assign rc_r    = (rc_t >= {1'b0, repeat_period}) ? rc_t - {1'b0, repeat_period} : rc_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
		end else if (ctrl.update) begin
			count_q <= cnt_n;
			rem_q   <= rem_n;
		end else if (ctrl.rc_step) begin
			rem_q   <= rc_r[COUNT_W-1:0];
		end
	end

	assign live           = (cnt_n != RELEASED_MARK);
	assign flags.pressed  = (cnt_n == 8'd1);
	assign flags.released = !live;
	assign flags.held     = live && ({1'b0, cnt_n} == ({1'b0, hold_frames} + 9'd1));
	assign flags.rpt      = live && (cnt_n != '0) &&
	                        ((repeat_period == '0) || (rem_n == 8'd1));
	assign count_next     = cnt_n;

endmodule

FILE: design/bht_merge.sv
`timescale 1ns / 1ps

module bht_merge import bht_pkg::*; #(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic               clk,
	input  logic               load,
	input  lane_flags_t        flags [BUTTON_COUNT],
	input  logic [COUNT_W-1:0] counts [BUTTON_COUNT],
	input  logic [QUERY_W-1:0] query_button,
	output out_item_t          result
);

	localparam int MASK_LANES = (BUTTON_COUNT < INPUT_BITS) ? BUTTON_COUNT : INPUT_BITS;

	out_item_t          res_n;
	out_item_t          result_q;
	logic [COUNT_W-1:0] sel;

	always_comb begin
		res_n = '0;
		sel   = '0;
		for (int i = 0; i < MASK_LANES; i++) begin
			res_n.pressed_mask[i]  = flags[i].pressed;
			res_n.released_mask[i] = flags[i].released;
			res_n.held_mask[i]     = flags[i].held;
			res_n.repeat_mask[i]   = flags[i].rpt;
			if (query_button == QUERY_W'(i)) begin
				sel = counts[i];
			end
		end
		// released marker reads as zero hold time
		res_n.held_time = (sel == RELEASED_MARK) ? '0 : sel;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res_n;
		end
	end

	assign result = result_q;

endmodule

FILE: design/button_hold_tracker_core.sv
`timescale 1ns / 1ps

// Channel | Handshake                 | Payload
// in      | in_valid / in_stall       | in_data  (in_item_t)
// out     | out_valid / out_stall     | out_data (out_item_t)
// cfg     | cfg_write                 | cfg_index, cfg_data
//
// One sample per cycle while in_stall is low; the result appears in the cycle
// after the input transfer. All button lanes update in parallel; the output
// register takes a new sample at the edge where the previous result transfers
// out, and in_stall is high while a result waits on out_stall.
// A write to repeat_period starts a remainder rebuild over the eight count bits,
// MSB first (one bit per cycle in every lane); in_stall is high during it.
// Reset clears all hold counters to idle, hold_frames to 20, repeat_period to 0.

module button_hold_tracker_core import bht_pkg::*; #(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [COUNT_W-1:0] hold_frames_q;
	logic [COUNT_W-1:0] repeat_period_q;
	logic               busy_q;
	logic               rc_first_q;
	logic [2:0]         rc_bit_q;
	logic               out_valid_q;
	logic               load;
	logic               rp_write;
	lane_ctrl_t         ctrl;
	lane_flags_t        flags [BUTTON_COUNT];
	logic [COUNT_W-1:0] counts [BUTTON_COUNT];

	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign load     = in_valid && !in_stall;
	assign rp_write = cfg_write && (cfg_index == REG_REPEAT_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_frames_q   <= HOLD_FRAMES_RST;
			repeat_period_q <= REPEAT_PERIOD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HOLD_FRAMES:   hold_frames_q   <= cfg_data;
				REG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// remainder rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rc_first_q <= 1'b0;
			rc_bit_q   <= '0;
		end else if (rp_write) begin
			busy_q     <= 1'b1;
			rc_first_q <= 1'b1;
			rc_bit_q   <= 3'd7;
		end else if (busy_q) begin
			rc_first_q <= 1'b0;
			rc_bit_q   <= rc_bit_q - 3'd1;
			if (rc_bit_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign ctrl.update   = load;
	assign ctrl.tick     = in_data.frame_tick;
	assign ctrl.rc_step  = busy_q;
	assign ctrl.rc_first = rc_first_q;
	assign ctrl.rc_bit   = rc_bit_q;

	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
		logic down;
		if (g < INPUT_BITS) begin : g_in
			assign down = in_data.buttons_down[g];
		end else begin : g_none
			assign down = 1'b0;
		end

		bht_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.down          (down),
			.hold_frames   (hold_frames_q),
			.repeat_period (repeat_period_q),
			.flags         (flags[g]),
			.count_next    (counts[g])
		);
	end

	bht_merge #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_merge (
		.clk          (clk),
		.load         (load),
		.flags        (flags),
		.counts       (counts),
		.query_button (in_data.query_button),
		.result       (out_data)
	);

	assign out_valid = out_valid_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("sample accepted during remainder rebuild");

	a_rp_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		rp_write |=> (busy_q && rc_first_q && rc_bit_q == 3'd7))
		else $error("repeat_period write did not start rebuild");

	a_rebuild_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rc_bit_q == '0 && !rp_write) |=> !busy_q)
		else $error("rebuild did not finish after last bit");

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("transfer did not produce a result");

endmodule
